>>> src/sgrp_pkg.sv
package sgrp_pkg;

    // Codes, seen through a 7-bit window; anything at or above 128 reads as CODE_NONE
    localparam logic [6:0] CODE_RESET     = 7'd0;
    localparam logic [6:0] CODE_BOLD      = 7'd1;
    localparam logic [6:0] CODE_FAINT     = 7'd2;
    localparam logic [6:0] CODE_ITALIC    = 7'd3;
    localparam logic [6:0] CODE_UNDERLINE = 7'd4;
    localparam logic [6:0] CODE_BLINK     = 7'd5;
    localparam logic [6:0] CODE_BLINK_FAST = 7'd6;
    localparam logic [6:0] CODE_INVERSE   = 7'd7;
    localparam logic [6:0] CODE_CONCEAL   = 7'd8;
    localparam logic [6:0] CODE_STRIKE    = 7'd9;
    localparam logic [6:0] CODE_NO_BOLD   = 7'd21;
    localparam logic [6:0] CODE_NORMAL    = 7'd22;
    localparam logic [6:0] CODE_NO_ITALIC = 7'd23;
    localparam logic [6:0] CODE_NO_UNDER  = 7'd24;
    localparam logic [6:0] CODE_NO_BLINK  = 7'd25;
    localparam logic [6:0] CODE_NO_INV    = 7'd27;
    localparam logic [6:0] CODE_NO_CONC   = 7'd28;
    localparam logic [6:0] CODE_NO_STRIKE = 7'd29;
    localparam logic [6:0] CODE_FG_BASE   = 7'd30;
    localparam logic [6:0] CODE_FG_TOP    = 7'd37;
    localparam logic [6:0] CODE_FG_EXT    = 7'd38;
    localparam logic [6:0] CODE_FG_DEF    = 7'd39;
    localparam logic [6:0] CODE_BG_BASE   = 7'd40;
    localparam logic [6:0] CODE_BG_TOP    = 7'd47;
    localparam logic [6:0] CODE_BG_EXT    = 7'd48;
    localparam logic [6:0] CODE_BG_DEF    = 7'd49;
    localparam logic [6:0] CODE_FG_HI_BASE = 7'd90;
    localparam logic [6:0] CODE_FG_HI_TOP = 7'd97;
    localparam logic [6:0] CODE_BG_HI_BASE = 7'd100;
    localparam logic [6:0] CODE_BG_HI_TOP = 7'd107;
    localparam logic [6:0] CODE_NONE      = 7'd127;

    localparam logic [6:0] SEL_INDEX = 7'd5;
    localparam logic [6:0] SEL_RGB   = 7'd2;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_BASIC   = 2'd1;
    localparam logic [1:0] KIND_INDEX   = 2'd2;
    localparam logic [1:0] KIND_RGB     = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic OP_BODY = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic [7:0]  style_flags;
        logic [1:0]  fore_kind;
        logic [23:0] fore_value;
        logic [1:0]  back_kind;
        logic [23:0] back_value;
    } t_result;

endpackage

>>> src/sgrp_fifo.sv
module sgrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr;
    logic [AW:0]      r_rd;
    logic [AW:0]      n_wr;
    logic [AW:0]      n_rd;
    logic             do_push;
    logic             do_pop;
    logic [AW:0]      count;

    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_empty = (r_wr == r_rd);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign n_wr    = r_wr + (AW+1)'(1);
    assign n_rd    = r_rd + (AW+1)'(1);
    assign o_data  = r_mem[r_rd[AW-1:0]];
    assign count   = r_wr - r_rd;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= (AW+1)'(DEPTH))
        else $error("fifo count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (count == $past(count) + (AW+1)'(1)))
        else $error("fifo count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (count == $past(count) - (AW+1)'(1)))
        else $error("fifo count did not shrink on pop");
`endif

endmodule

>>> src/sgrp_front.sv
module sgrp_front #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_opcode,
    input  logic [7:0]            i_body_byte,
    input  logic                  i_tok_full,
    output logic                  o_tok_push,
    output logic [NUMBER_WIDTH:0] o_tok_data
);

    localparam int PW = NUMBER_WIDTH + 4;
    localparam logic [NUMBER_WIDTH-1:0] ACC_MAX = '1;

    logic [NUMBER_WIDTH-1:0] r_acc;
    logic [NUMBER_WIDTH-1:0] n_acc;
    logic                    accept;
    logic                    is_digit;
    logic [7:0]              digit;
    logic [PW-1:0]           prod;

    assign accept   = i_push && !i_tok_full;
    assign is_digit = (i_body_byte >= sgrp_pkg::CHAR_ZERO) && (i_body_byte <= sgrp_pkg::CHAR_NINE);
    assign digit    = i_body_byte - sgrp_pkg::CHAR_ZERO;
    assign prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + PW'(digit[3:0]);

    // token: end flag over the closed parameter
    assign o_tok_push = accept && ((i_opcode == sgrp_pkg::OP_END) ||
                                   (i_body_byte == sgrp_pkg::CHAR_SEMI));
    assign o_tok_data = {i_opcode, r_acc};

    always_comb begin
        n_acc = r_acc;
        if (o_tok_push) begin
            n_acc = '0;
        end else if (accept && is_digit) begin
            n_acc = (prod > PW'(ACC_MAX)) ? ACC_MAX : prod[NUMBER_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

>>> src/sgrp_back.sv
module sgrp_back #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tok_empty,
    input  logic [NUMBER_WIDTH:0] i_tok_data,
    output logic                  o_tok_pop,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output sgrp_pkg::t_result     o_res_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEL,
        PH_IDX,
        PH_RED,
        PH_GREEN,
        PH_BLUE
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_to_back;
    logic        n_to_back;
    logic [7:0]  r_red;
    logic [7:0]  n_red;
    logic [7:0]  r_green;
    logic [7:0]  n_green;
    logic [7:0]  r_flags;
    logic [7:0]  n_flags;
    logic [1:0]  r_fk;
    logic [1:0]  n_fk;
    logic [23:0] r_fv;
    logic [23:0] n_fv;
    logic [1:0]  r_bk;
    logic [1:0]  n_bk;
    logic [23:0] r_bv;
    logic [23:0] n_bv;

    logic                    tok_end;
    logic [NUMBER_WIDTH-1:0] v;
    logic [7:0]              low8;
    logic [6:0]              code;
    logic [6:0]              off;
    logic                    do_apply;
    logic                    ext_set;
    logic [1:0]              ext_kind;
    logic [23:0]             ext_val;

    assign tok_end    = i_tok_data[NUMBER_WIDTH];
    assign v          = i_tok_data[NUMBER_WIDTH-1:0];
    assign low8       = v[7:0];
    assign code       = (|v[NUMBER_WIDTH-1:7]) ? sgrp_pkg::CODE_NONE : v[6:0];
    assign o_tok_pop  = !i_tok_empty && (!tok_end || !i_res_full);
    assign o_res_push = o_tok_pop && tok_end;
    assign o_res_data = '{style_flags: n_flags, fore_kind: n_fk, fore_value: n_fv,
                          back_kind: n_bk, back_value: n_bv};

    always_comb begin
        n_phase   = r_phase;
        n_to_back = r_to_back;
        n_red     = r_red;
        n_green   = r_green;
        n_flags   = r_flags;
        n_fk      = r_fk;
        n_fv      = r_fv;
        n_bk      = r_bk;
        n_bv      = r_bv;
        do_apply  = 1'b0;
        ext_set   = 1'b0;
        ext_kind  = sgrp_pkg::KIND_INDEX;
        ext_val   = {16'd0, low8};
        off       = '0;

        if (o_tok_pop) begin
            case (r_phase)
                PH_SEL: begin
                    n_phase = PH_IDLE;
                    if (code == sgrp_pkg::SEL_INDEX) begin
                        n_phase = PH_IDX;
                    end else if (code == sgrp_pkg::SEL_RGB) begin
                        n_phase = PH_RED;
                    end else begin
                        do_apply = 1'b1;
                    end
                end
                PH_IDX: begin
                    ext_set = 1'b1;
                    n_phase = PH_IDLE;
                end
                PH_RED: begin
                    n_red   = low8;
                    n_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    n_green = low8;
                    n_phase = PH_BLUE;
                end
                PH_BLUE: begin
                    ext_set  = 1'b1;
                    ext_kind = sgrp_pkg::KIND_RGB;
                    ext_val  = {r_red, r_green, low8};
                    n_phase  = PH_IDLE;
                end
                default: begin
                    n_phase  = PH_IDLE;
                    do_apply = 1'b1;
                end
            endcase

            if (ext_set) begin
                if (r_to_back) begin
                    n_bk = ext_kind;
                    n_bv = ext_val;
                end else begin
                    n_fk = ext_kind;
                    n_fv = ext_val;
                end
            end

            if (do_apply) begin
                case (code)
                    sgrp_pkg::CODE_RESET: begin
                        n_flags = '0;
                        n_fk    = sgrp_pkg::KIND_DEFAULT;
                        n_fv    = '0;
                        n_bk    = sgrp_pkg::KIND_DEFAULT;
                        n_bv    = '0;
                    end
                    sgrp_pkg::CODE_BOLD:       n_flags = r_flags | 8'h01;
                    sgrp_pkg::CODE_FAINT:      n_flags = r_flags | 8'h02;
                    sgrp_pkg::CODE_ITALIC:     n_flags = r_flags | 8'h04;
                    sgrp_pkg::CODE_UNDERLINE:  n_flags = r_flags | 8'h08;
                    sgrp_pkg::CODE_BLINK,
                    sgrp_pkg::CODE_BLINK_FAST: n_flags = r_flags | 8'h10;
                    sgrp_pkg::CODE_INVERSE:    n_flags = r_flags | 8'h20;
                    sgrp_pkg::CODE_CONCEAL:    n_flags = r_flags | 8'h40;
                    sgrp_pkg::CODE_STRIKE:     n_flags = r_flags | 8'h80;
                    sgrp_pkg::CODE_NO_BOLD,
                    sgrp_pkg::CODE_NORMAL:     n_flags = r_flags & ~8'h03;
                    sgrp_pkg::CODE_NO_ITALIC:  n_flags = r_flags & ~8'h04;
                    sgrp_pkg::CODE_NO_UNDER:   n_flags = r_flags & ~8'h08;
                    sgrp_pkg::CODE_NO_BLINK:   n_flags = r_flags & ~8'h10;
                    sgrp_pkg::CODE_NO_INV:     n_flags = r_flags & ~8'h20;
                    sgrp_pkg::CODE_NO_CONC:    n_flags = r_flags & ~8'h40;
                    sgrp_pkg::CODE_NO_STRIKE:  n_flags = r_flags & ~8'h80;
                    sgrp_pkg::CODE_FG_DEF: begin
                        n_fk = sgrp_pkg::KIND_DEFAULT;
                        n_fv = '0;
                    end
                    sgrp_pkg::CODE_BG_DEF: begin
                        n_bk = sgrp_pkg::KIND_DEFAULT;
                        n_bv = '0;
                    end
                    sgrp_pkg::CODE_FG_EXT: begin
                        n_to_back = 1'b0;
                        n_phase   = PH_SEL;
                    end
                    sgrp_pkg::CODE_BG_EXT: begin
                        n_to_back = 1'b1;
                        n_phase   = PH_SEL;
                    end
                    default: begin
                        if (code inside {[sgrp_pkg::CODE_FG_BASE:sgrp_pkg::CODE_FG_TOP]}) begin
                            off  = code - sgrp_pkg::CODE_FG_BASE;
                            n_fk = sgrp_pkg::KIND_BASIC;
                            n_fv = {21'd0, off[2:0]};
                        end else if (code inside
                                     {[sgrp_pkg::CODE_BG_BASE:sgrp_pkg::CODE_BG_TOP]}) begin
                            off  = code - sgrp_pkg::CODE_BG_BASE;
                            n_bk = sgrp_pkg::KIND_BASIC;
                            n_bv = {21'd0, off[2:0]};
                        end else if (code inside
                                     {[sgrp_pkg::CODE_FG_HI_BASE:sgrp_pkg::CODE_FG_HI_TOP]}) begin
                            off  = code - sgrp_pkg::CODE_FG_HI_BASE;
                            n_fk = sgrp_pkg::KIND_BASIC;
                            n_fv = {20'd0, 1'b1, off[2:0]};
                        end else if (code inside
                                     {[sgrp_pkg::CODE_BG_HI_BASE:sgrp_pkg::CODE_BG_HI_TOP]}) begin
                            off  = code - sgrp_pkg::CODE_BG_HI_BASE;
                            n_bk = sgrp_pkg::KIND_BASIC;
                            n_bv = {20'd0, 1'b1, off[2:0]};
                        end
                    end
                endcase
            end

            // end marker drops any unfinished extended sequence
            if (tok_end) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_to_back <= 1'b0;
            r_red     <= '0;
            r_green   <= '0;
            r_flags   <= '0;
            r_fk      <= sgrp_pkg::KIND_DEFAULT;
            r_fv      <= '0;
            r_bk      <= sgrp_pkg::KIND_DEFAULT;
            r_bv      <= '0;
        end else begin
            r_phase   <= n_phase;
            r_to_back <= n_to_back;
            r_red     <= n_red;
            r_green   <= n_green;
            r_flags   <= n_flags;
            r_fk      <= n_fk;
            r_fv      <= n_fv;
            r_bk      <= n_bk;
            r_bv      <= n_bv;
        end
    end

`ifndef ASSERT_OFF
    a_end_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_phase == PH_IDLE))
        else $error("phase not idle after end marker");

    a_default_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fk != sgrp_pkg::KIND_DEFAULT || r_fv == '0) &&
        (r_bk != sgrp_pkg::KIND_DEFAULT || r_bv == '0))
        else $error("default colour with nonzero value");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_tok_pop |=> ($stable(r_flags) && $stable(r_phase) && $stable(r_fv) &&
                        $stable(r_bv)))
        else $error("attributes changed without a parameter");
`endif

endmodule

>>> src/sgr_attribute_parser_top.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// request  | in        | i_push / o_full      | i_opcode, i_body_byte
// result   | out       | o_empty / i_pop      | o_style_flags, o_fore_kind, o_fore_value,
//          |           |                      | o_back_kind, o_back_value
//
// One request per cycle while o_full is low; a digit, ';' or end marker is parsed in the
// cycle it is taken. Closed parameters cross a TOKEN_DEPTH queue to the attribute stage, one
// per cycle unless it stalls. An end marker's result enters the result queue at the edge its
// token leaves the token queue, so o_empty falls only after that pop. o_full rises only when
// the token queue is full; a full result queue stalls the attribute stage at an end marker.
// Synchronous active-low reset empties both queues and returns attributes to default.
module sgr_attribute_parser_top #(
    parameter int NUMBER_WIDTH = 16,
    parameter int TOKEN_DEPTH  = 4,
    parameter int RESULT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_opcode,
    input  logic [7:0]  i_body_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_style_flags,
    output logic [1:0]  o_fore_kind,
    output logic [23:0] o_fore_value,
    output logic [1:0]  o_back_kind,
    output logic [23:0] o_back_value
);

    localparam int RW = $bits(sgrp_pkg::t_result);

    logic                  tok_push;
    logic [NUMBER_WIDTH:0] tok_wdata;
    logic                  tok_full;
    logic                  tok_pop;
    logic [NUMBER_WIDTH:0] tok_rdata;
    logic                  tok_empty;
    logic                  res_push;
    logic                  res_full;
    sgrp_pkg::t_result     res_wdata;
    sgrp_pkg::t_result     res_rdata;

    assign o_full        = tok_full;
    assign o_style_flags = res_rdata.style_flags;
    assign o_fore_kind   = res_rdata.fore_kind;
    assign o_fore_value  = res_rdata.fore_value;
    assign o_back_kind   = res_rdata.back_kind;
    assign o_back_value  = res_rdata.back_value;

    sgrp_front #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_opcode   (i_opcode),
        .i_body_byte(i_body_byte),
        .i_tok_full (tok_full),
        .o_tok_push (tok_push),
        .o_tok_data (tok_wdata)
    );

    sgrp_fifo #(
        .WIDTH(NUMBER_WIDTH + 1),
        .DEPTH(TOKEN_DEPTH)
    ) u_tok_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (tok_push),
        .i_data (tok_wdata),
        .o_full (tok_full),
        .i_pop  (tok_pop),
        .o_data (tok_rdata),
        .o_empty(tok_empty)
    );

    sgrp_back #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok_empty(tok_empty),
        .i_tok_data (tok_rdata),
        .o_tok_pop  (tok_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_data (res_wdata)
    );

    sgrp_fifo #(
        .WIDTH(RW),
        .DEPTH(RESULT_DEPTH)
    ) u_res_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_wdata),
        .o_full (res_full),
        .i_pop  (i_pop),
        .o_data (res_rdata),
        .o_empty(o_empty)
    );

endmodule

>>> verif/sgr_attribute_parser_top_tb.sv
`timescale 1ns / 100ps

module sgr_attribute_parser_top_tb;

    localparam int          NUM_WIDTH = 16;
    localparam logic [31:0] ACC_MAX   = (32'd1 << NUM_WIDTH) - 32'd1;
    localparam int          ITEM_GOAL = 1950;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SEL, PH_IDX, PH_RED, PH_GREEN, PH_BLUE
    } t_ext_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic        i_opcode;
    logic [7:0]  i_body_byte;
    logic        o_empty;
    logic        i_pop;
    logic [7:0]  o_style_flags;
    logic [1:0]  o_fore_kind;
    logic [23:0] o_fore_value;
    logic [1:0]  o_back_kind;
    logic [23:0] o_back_value;

    sgr_attribute_parser_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_opcode     (i_opcode),
        .i_body_byte  (i_body_byte),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_style_flags(o_style_flags),
        .o_fore_kind  (o_fore_kind),
        .o_fore_value (o_fore_value),
        .o_back_kind  (o_back_kind),
        .o_back_value (o_back_value)
    );

    always #4 i_clk = ~i_clk;

    // Attribute tracker state
    logic [NUM_WIDTH-1:0] acc_q      = '0;
    bit                   digit_q    = 1'b0;
    t_ext_phase           phase_q    = PH_IDLE;
    bit                   ext_back_q = 1'b0;
    logic [7:0]           red_q      = '0;
    logic [7:0]           green_q    = '0;
    logic [7:0]           flags_q    = '0;
    logic [1:0]           fg_kind_q  = sgrp_pkg::KIND_DEFAULT;
    logic [23:0]          fg_val_q   = '0;
    logic [1:0]           bg_kind_q  = sgrp_pkg::KIND_DEFAULT;
    logic [23:0]          bg_val_q   = '0;

    sgrp_pkg::t_result expected_attrs[$];
    int unsigned       errors       = 0;
    int unsigned       sent_count   = 0;
    int unsigned       stall_cycles = 0;
    bit                idle_on      = 1'b1;

    function automatic void set_ext_colour(logic [1:0] kind, logic [23:0] val);
        if (ext_back_q) begin
            bg_kind_q = kind;
            bg_val_q  = val;
        end else begin
            fg_kind_q = kind;
            fg_val_q  = val;
        end
    endfunction

    function automatic void apply_sgr_code(logic [31:0] code);
        case (code)
            sgrp_pkg::CODE_RESET: begin
                flags_q   = '0;
                fg_kind_q = sgrp_pkg::KIND_DEFAULT;
                fg_val_q  = '0;
                bg_kind_q = sgrp_pkg::KIND_DEFAULT;
                bg_val_q  = '0;
            end
            sgrp_pkg::CODE_BOLD:       flags_q[0] = 1'b1;
            sgrp_pkg::CODE_FAINT:      flags_q[1] = 1'b1;
            sgrp_pkg::CODE_ITALIC:     flags_q[2] = 1'b1;
            sgrp_pkg::CODE_UNDERLINE:  flags_q[3] = 1'b1;
            sgrp_pkg::CODE_BLINK,
            sgrp_pkg::CODE_BLINK_FAST: flags_q[4] = 1'b1;
            sgrp_pkg::CODE_INVERSE:    flags_q[5] = 1'b1;
            sgrp_pkg::CODE_CONCEAL:    flags_q[6] = 1'b1;
            sgrp_pkg::CODE_STRIKE:     flags_q[7] = 1'b1;
            sgrp_pkg::CODE_NO_BOLD,
            sgrp_pkg::CODE_NORMAL:     flags_q[1:0] = 2'b00;
            sgrp_pkg::CODE_NO_ITALIC:  flags_q[2] = 1'b0;
            sgrp_pkg::CODE_NO_UNDER:   flags_q[3] = 1'b0;
            sgrp_pkg::CODE_NO_BLINK:   flags_q[4] = 1'b0;
            sgrp_pkg::CODE_NO_INV:     flags_q[5] = 1'b0;
            sgrp_pkg::CODE_NO_CONC:    flags_q[6] = 1'b0;
            sgrp_pkg::CODE_NO_STRIKE:  flags_q[7] = 1'b0;
            sgrp_pkg::CODE_FG_DEF: begin
                fg_kind_q = sgrp_pkg::KIND_DEFAULT;
                fg_val_q  = '0;
            end
            sgrp_pkg::CODE_BG_DEF: begin
                bg_kind_q = sgrp_pkg::KIND_DEFAULT;
                bg_val_q  = '0;
            end
            sgrp_pkg::CODE_FG_EXT, sgrp_pkg::CODE_BG_EXT: begin
                ext_back_q = (code == sgrp_pkg::CODE_BG_EXT);
                phase_q    = PH_SEL;
            end
            default: begin
                if (code >= sgrp_pkg::CODE_FG_BASE && code <= sgrp_pkg::CODE_FG_TOP) begin
                    fg_kind_q = sgrp_pkg::KIND_BASIC;
                    fg_val_q  = 24'(code - sgrp_pkg::CODE_FG_BASE);
                end else if (code >= sgrp_pkg::CODE_BG_BASE &&
                             code <= sgrp_pkg::CODE_BG_TOP) begin
                    bg_kind_q = sgrp_pkg::KIND_BASIC;
                    bg_val_q  = 24'(code - sgrp_pkg::CODE_BG_BASE);
                end else if (code >= sgrp_pkg::CODE_FG_HI_BASE &&
                             code <= sgrp_pkg::CODE_FG_HI_TOP) begin
                    fg_kind_q = sgrp_pkg::KIND_BASIC;
                    fg_val_q  = 24'(code - sgrp_pkg::CODE_FG_HI_BASE + 32'd8);
                end else if (code >= sgrp_pkg::CODE_BG_HI_BASE &&
                             code <= sgrp_pkg::CODE_BG_HI_TOP) begin
                    bg_kind_q = sgrp_pkg::KIND_BASIC;
                    bg_val_q  = 24'(code - sgrp_pkg::CODE_BG_HI_BASE + 32'd8);
                end
            end
        endcase
    endfunction

    function automatic void close_parameter();
        logic [31:0] v;
        v = digit_q ? 32'(acc_q) : 32'd0;
        case (phase_q)
            PH_SEL: begin
                phase_q = PH_IDLE;
                if (v == sgrp_pkg::SEL_INDEX)
                    phase_q = PH_IDX;
                else if (v == sgrp_pkg::SEL_RGB)
                    phase_q = PH_RED;
                else
                    apply_sgr_code(v);
            end
            PH_IDX: begin
                set_ext_colour(sgrp_pkg::KIND_INDEX, {16'h0000, v[7:0]});
                phase_q = PH_IDLE;
            end
            PH_RED: begin
                red_q   = v[7:0];
                phase_q = PH_GREEN;
            end
            PH_GREEN: begin
                green_q = v[7:0];
                phase_q = PH_BLUE;
            end
            PH_BLUE: begin
                set_ext_colour(sgrp_pkg::KIND_RGB, {red_q, green_q, v[7:0]});
                phase_q = PH_IDLE;
            end
            default: begin
                phase_q = PH_IDLE;
                apply_sgr_code(v);
            end
        endcase
        acc_q   = '0;
        digit_q = 1'b0;
    endfunction

    function automatic void track_attributes(logic op, logic [7:0] b);
        logic [31:0]       n;
        sgrp_pkg::t_result r;
        if (op == sgrp_pkg::OP_BODY) begin
            if (b >= sgrp_pkg::CHAR_ZERO && b <= sgrp_pkg::CHAR_NINE) begin
                n = 32'(acc_q) * 32'd10 + 32'(b - sgrp_pkg::CHAR_ZERO);
                if (n > ACC_MAX)
                    n = ACC_MAX;
                acc_q   = n[NUM_WIDTH-1:0];
                digit_q = 1'b1;
            end else if (b == sgrp_pkg::CHAR_SEMI) begin
                close_parameter();
            end
        end else begin
            close_parameter();
            phase_q       = PH_IDLE;
            r.style_flags = flags_q;
            r.fore_kind   = fg_kind_q;
            r.fore_value  = fg_val_q;
            r.back_kind   = bg_kind_q;
            r.back_value  = bg_val_q;
            expected_attrs = {expected_attrs, r};
        end
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result();
        sgrp_pkg::t_result want;
        if (expected_attrs.size() == 0) begin
            report_mismatch("result with nothing expected");
            return;
        end
        want = expected_attrs.pop_front();
        if (o_style_flags !== want.style_flags)
            report_mismatch($sformatf("style_flags %h want %h", o_style_flags, want.style_flags));
        if (o_fore_kind !== want.fore_kind)
            report_mismatch($sformatf("fore_kind %h want %h", o_fore_kind, want.fore_kind));
        if (o_fore_value !== want.fore_value)
            report_mismatch($sformatf("fore_value %h want %h", o_fore_value, want.fore_value));
        if (o_back_kind !== want.back_kind)
            report_mismatch($sformatf("back_kind %h want %h", o_back_kind, want.back_kind));
        if (o_back_value !== want.back_value)
            report_mismatch($sformatf("back_value %h want %h", o_back_value, want.back_value));
    endtask

    // Entered and left at a falling edge.
    task automatic send_request(input logic op, input logic [7:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_push <= 1'b0;
            repeat (gap) begin
                i_opcode    <= 1'($urandom_range(0, 1));
                i_body_byte <= 8'($urandom_range(0, 255));
                @(negedge i_clk);
            end
        end
        i_push      <= 1'b1;
        i_opcode    <= op;
        i_body_byte <= b;
        do @(posedge i_clk); while (o_full);
        track_attributes(op, b);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit noisy);
        for (int i = 0; i < s.len(); i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_request(sgrp_pkg::OP_BODY, 8'($urandom_range(0, 255)));
            send_request(sgrp_pkg::OP_BODY, s[i]);
        end
    endtask

    task automatic send_sgr(input string s);
        send_text(s, 1'b0);
        send_request(sgrp_pkg::OP_END, 8'($urandom_range(0, 255)));
    endtask

    function automatic string num_text(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"0", s};
        return s;
    endfunction

    // Mostly well-formed parameter lists; extended colors may be cut short.
    function automatic string build_sequence();
        string       s;
        string       p;
        int unsigned n_params;
        int unsigned r;
        int unsigned sel;
        bit          stop;
        s        = "";
        stop     = 1'b0;
        n_params = $urandom_range(1, 6);
        for (int k = 0; k < n_params && !stop; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                p = num_text($urandom_range(0, 107));
            end else if (r < 55) begin
                p   = $urandom_range(0, 1) ? "48" : "38";
                sel = $urandom_range(0, 19);
                if (sel < 12) begin
                    p = {p, ";5"};
                    if ($urandom_range(0, 9) == 0)
                        stop = 1'b1;
                    else
                        p = {p, ";", num_text($urandom_range(0, 300))};
                end else if (sel < 18) begin
                    p = {p, ";2"};
                    for (int c = 0; c < 3 && !stop; c++) begin
                        if ($urandom_range(0, 15) == 0)
                            stop = 1'b1;
                        else
                            p = {p, ";", num_text($urandom_range(0, 300))};
                    end
                end else begin
                    p = {p, ";", num_text($urandom_range(0, 20))};
                end
            end else if (r < 65) begin
                p = "";
            end else if (r < 75) begin
                p = num_text($urandom_range(60000, 9999999));
            end else begin
                p = num_text($urandom_range(0, 255));
            end
            s = (k == 0) ? p : {s, ";", p};
        end
        return s;
    endfunction

    task automatic test_reset_state();
        send_request(sgrp_pkg::OP_END, 8'hFF);
    endtask

    task automatic test_style_codes();
        send_sgr("1;2;3;4;5;7;8;9");
        send_sgr("21;23;24;25;27;28;29;6");
        send_sgr("22;0");
    endtask

    task automatic test_basic_colours();
        send_sgr("31;107");
        send_sgr("97;40;39");
        send_sgr("49");
    endtask

    task automatic test_extended_colours();
        send_sgr("38;5;300;48;2;255;256;1");
        send_sgr("48;9;1");
        send_sgr("38;2;7;8");
        send_sgr("5");
    endtask

    task automatic test_odd_bytes();
        send_text("4", 1'b0);
        send_request(sgrp_pkg::OP_BODY, 8'h00);
        send_request(sgrp_pkg::OP_BODY, 8'hFF);
        send_sgr("99999;;158");
        send_sgr("1;133;65535;65536");
    endtask

    task automatic test_back_pressure();
        idle_on      = 1'b0;
        stall_cycles = 300;
        repeat (12) send_sgr("3");
        idle_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        int unsigned kind;
        int unsigned seq_n;
        seq_n = 0;
        while (sent_count < ITEM_GOAL) begin
            if (seq_n % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 8))
                    send_request(sgrp_pkg::OP_BODY, 8'($urandom_range(0, 255)));
            end else begin
                send_text(build_sequence(), kind == 1);
            end
            if ($urandom_range(0, 19) != 0)
                send_request(sgrp_pkg::OP_END, 8'($urandom_range(0, 255)));
            seq_n++;
        end
        idle_on = 1'b1;
    endtask

    // Result side: random pop gaps, plus long hold-offs on request.
    initial begin : result_side
        int unsigned pop_gap;
        bit          took;
        pop_gap = 0;
        i_pop   = 1'b0;
        @(negedge i_clk);
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            took = i_pop && !o_empty;
            if (took)
                check_result();
            @(negedge i_clk);
            if (stall_cycles != 0) begin
                stall_cycles--;
                i_pop <= 1'b0;
            end else if (took || !i_pop) begin
                if (took)
                    pop_gap = idle_on ? $urandom_range(0, 4) : 0;
                if (pop_gap != 0) begin
                    pop_gap--;
                    i_pop <= 1'b0;
                end else begin
                    i_pop <= 1'b1;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_opcode    = sgrp_pkg::OP_BODY;
        i_body_byte = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_style_codes();
        test_basic_colours();
        test_extended_colours();
        test_odd_bytes();
        test_back_pressure();
        test_random_sequences();

        i_push <= 1'b0;
        while (expected_attrs.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
